### src/rsm_pkg.sv
// ----------------------------------------------------------------------------
// Supervisory mode controller package
// Shared types and constants: the tick word, the configuration register set,
// register indexes, register reset values, event codes and ramp codes.
// ----------------------------------------------------------------------------
package rsm_pkg;

  // One update tick as it travels from the input register to the core.
  typedef struct packed {
    logic [31:0] now_ms;
    logic [2:0]  event_code;
    logic [3:0]  cmd_direction;
    logic [7:0]  cmd_speed;
    logic        recovery_is_emergency;
  } item_t;

  // Configuration register set.
  typedef struct packed {
    logic [15:0] recovery_entry_window_ms;
    logic [19:0] recovery_duration_ms;
    logic [19:0] estop_hold_ms;
    logic [19:0] home_return_ms;
    logic [19:0] error_hold_ms;
    logic [3:0]  stop_direction_code;
  } cfg_t;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REC_DURATION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESTOP_HOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_RETURN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_HOLD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DIR     = 3'd5;

  // Register reset values.
  localparam logic [15:0] RST_ENTRY_WINDOW = 16'd100;
  localparam logic [19:0] RST_REC_DURATION = 20'd3000;
  localparam logic [19:0] RST_ESTOP_HOLD   = 20'd5000;
  localparam logic [19:0] RST_HOME_RETURN  = 20'd10000;
  localparam logic [19:0] RST_ERROR_HOLD   = 20'd3000;
  localparam logic [3:0]  RST_STOP_DIR     = 4'd0;

  // Event codes of a tick word; the spare code matches no event.
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_COMMAND    = 3'd1;
  localparam logic [2:0] EV_BUTTON     = 3'd2;
  localparam logic [2:0] EV_SMOKE      = 3'd3;
  localparam logic [2:0] EV_TIME_LIMIT = 3'd4;
  localparam logic [2:0] EV_STUCK      = 3'd5;
  localparam logic [2:0] EV_POWER_FAIL = 3'd6;
  localparam logic [2:0] EV_SPARE      = 3'd7;

  // Soft stop ramp codes.
  localparam logic [1:0] RAMP_NONE = 2'd0;
  localparam logic [1:0] RAMP_500  = 2'd1;
  localparam logic [1:0] RAMP_1000 = 2'd2;

endpackage

### src/rsm_cfg.sv
// ----------------------------------------------------------------------------
// Supervisory mode controller configuration registers
// Holds the timing limits and the stop direction code; a write is always
// taken in the cycle it is offered.
// ----------------------------------------------------------------------------
module rsm_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output rsm_pkg::cfg_t                 cfg
);

  rsm_pkg::cfg_t cfg_r;

  // The register file never needs to hold off a write.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Register writes; unknown indexes are dropped and data is cut to width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.recovery_entry_window_ms <= rsm_pkg::RST_ENTRY_WINDOW;
      cfg_r.recovery_duration_ms     <= rsm_pkg::RST_REC_DURATION;
      cfg_r.estop_hold_ms            <= rsm_pkg::RST_ESTOP_HOLD;
      cfg_r.home_return_ms           <= rsm_pkg::RST_HOME_RETURN;
      cfg_r.error_hold_ms            <= rsm_pkg::RST_ERROR_HOLD;
      cfg_r.stop_direction_code      <= rsm_pkg::RST_STOP_DIR;
    end else if (cfg_valid) begin
      case (cfg_index)
        rsm_pkg::REG_ENTRY_WINDOW: cfg_r.recovery_entry_window_ms <= cfg_wdata[15:0];
        rsm_pkg::REG_REC_DURATION: cfg_r.recovery_duration_ms     <= cfg_wdata;
        rsm_pkg::REG_ESTOP_HOLD:   cfg_r.estop_hold_ms            <= cfg_wdata;
        rsm_pkg::REG_HOME_RETURN:  cfg_r.home_return_ms           <= cfg_wdata;
        rsm_pkg::REG_ERROR_HOLD:   cfg_r.error_hold_ms            <= cfg_wdata;
        rsm_pkg::REG_STOP_DIR:     cfg_r.stop_direction_code      <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

endmodule

### src/rsm_in_stage.sv
// ----------------------------------------------------------------------------
// Supervisory mode controller input register
// Captures one tick word and holds it until the core takes it.
// ----------------------------------------------------------------------------
module rsm_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rsm_pkg::item_t in_item,
  input  logic           take,
  output logic           item_valid,
  output rsm_pkg::item_t item
);

  logic           valid_r;
  logic           valid_nxt;
  rsm_pkg::item_t item_r;
  logic           accept;

  // The register is free when empty or when its word leaves this cycle.
  assign in_stall   = valid_r && !take;
  assign accept     = in_valid && !in_stall;
  assign valid_nxt  = accept || (valid_r && !take);
  assign item_valid = valid_r;
  assign item       = item_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Word register.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

### src/rsm_core.sv
// ----------------------------------------------------------------------------
// Supervisory mode controller core
// Mode state machine: runs the handler of the current mode on one tick word,
// updates the mode and its flags, and registers the motor commands.
// ----------------------------------------------------------------------------
module rsm_core (
  input  logic           clk,
  input  logic           rst_n,
  input  rsm_pkg::cfg_t  cfg,
  input  logic           item_valid,
  input  rsm_pkg::item_t item,
  output logic           take,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2:0]     out_mode,
  output logic           out_drive_valid,
  output logic [3:0]     out_drive_direction,
  output logic [7:0]     out_drive_speed,
  output logic [1:0]     out_soft_stop_ramp,
  output logic           out_hard_stop,
  output logic           out_start_recovery,
  output logic           out_motors_allowed,
  output logic           out_estop_flag
);

  typedef enum logic [2:0] {
    M_INIT     = 3'd0,
    M_IDLE     = 3'd1,
    M_MANUAL   = 3'd2,
    M_AUTO     = 3'd3,
    M_RECOVERY = 3'd4,
    M_ESTOP    = 3'd5,
    M_HOME     = 3'd6,
    M_ERROR    = 3'd7
  } mode_t;

  // Mode state.
  mode_t       mode_r, mode_nxt;
  logic [31:0] entry_r, entry_nxt;
  logic        enable_r, enable_nxt;
  logic        estop_r, estop_nxt;
  logic        latched_r, latched_nxt;
  logic [31:0] rec_start_r, rec_start_nxt;
  logic        rec_emerg_r, rec_emerg_nxt;

  // Result register.
  logic        out_valid_r;
  logic        drive_r, drive_nxt;
  logic [3:0]  dir_r, dir_nxt;
  logic [7:0]  speed_r, speed_nxt;
  logic [1:0]  ramp_r, ramp_nxt;
  logic        hard_r, hard_nxt;
  logic        start_rec_r, start_rec_nxt;

  // Per-tick working signals.
  logic [31:0] in_mode;
  logic [31:0] rec_elapsed;
  logic        go;
  mode_t       target;
  logic        latch;
  logic        is_stop_dir;

  // A word moves on when the result register is empty or being emptied.
  assign take = item_valid && (!out_valid_r || !out_stall);

  assign in_mode     = item.now_ms - entry_r;
  assign rec_elapsed = item.now_ms - rec_start_r;
  assign is_stop_dir = (item.cmd_direction == cfg.stop_direction_code);
  assign latch       = (in_mode < {16'd0, cfg.recovery_entry_window_ms}) && !latched_r;

  // Mode handlers followed by the common exit and entry actions.
  always_comb begin
    mode_nxt      = mode_r;
    entry_nxt     = entry_r;
    enable_nxt    = enable_r;
    estop_nxt     = estop_r;
    latched_nxt   = latched_r;
    rec_start_nxt = rec_start_r;
    rec_emerg_nxt = rec_emerg_r;
    drive_nxt     = 1'b0;
    ramp_nxt      = rsm_pkg::RAMP_NONE;
    hard_nxt      = 1'b0;
    start_rec_nxt = 1'b0;
    go            = 1'b0;
    target        = mode_r;

    case (mode_r)
      M_INIT: begin
        go     = 1'b1;
        target = M_IDLE;
      end
      M_IDLE: begin
        if (item.event_code == rsm_pkg::EV_COMMAND && !is_stop_dir) begin
          go     = 1'b1;
          target = M_MANUAL;
        end else if (item.event_code == rsm_pkg::EV_BUTTON ||
                     item.event_code == rsm_pkg::EV_SMOKE) begin
          go     = 1'b1;
          target = M_ESTOP;
        end else if (item.event_code == rsm_pkg::EV_TIME_LIMIT) begin
          go     = 1'b1;
          target = M_HOME;
        end
      end
      M_MANUAL, M_AUTO: begin
        drive_nxt = enable_r && !estop_r;
        if (item.event_code == rsm_pkg::EV_STUCK) begin
          go     = 1'b1;
          target = M_RECOVERY;
        end else if (item.event_code == rsm_pkg::EV_BUTTON ||
                     item.event_code == rsm_pkg::EV_SMOKE ||
                     item.event_code == rsm_pkg::EV_POWER_FAIL) begin
          go     = 1'b1;
          target = M_ESTOP;
        end else if (item.event_code == rsm_pkg::EV_COMMAND && is_stop_dir) begin
          go     = 1'b1;
          target = M_IDLE;
        end else if (item.event_code == rsm_pkg::EV_TIME_LIMIT) begin
          go     = 1'b1;
          target = M_HOME;
        end
      end
      M_RECOVERY: begin
        if (latch) begin
          rec_emerg_nxt = item.recovery_is_emergency;
          start_rec_nxt = 1'b1;
          rec_start_nxt = item.now_ms;
          latched_nxt   = 1'b1;
        end
        // A button press wins over completion, even on a tick that would complete
        // the stay, and ends in emergency stop.
        if (item.event_code == rsm_pkg::EV_BUTTON) begin
          latched_nxt = 1'b0;
          go          = 1'b1;
          target      = M_ESTOP;
        end else if (!latch && rec_elapsed > {12'd0, cfg.recovery_duration_ms}) begin
          latched_nxt = 1'b0;
          go          = 1'b1;
          target      = rec_emerg_r ? M_ESTOP : M_IDLE;
        end
      end
      M_ESTOP: begin
        hard_nxt   = 1'b1;
        estop_nxt  = 1'b1;
        enable_nxt = 1'b0;
        if (in_mode > {12'd0, cfg.estop_hold_ms}) begin
          estop_nxt = 1'b0;
          go        = 1'b1;
          target    = M_IDLE;
        end
      end
      M_HOME: begin
        ramp_nxt = rsm_pkg::RAMP_1000;
        if (in_mode > {12'd0, cfg.home_return_ms}) begin
          go     = 1'b1;
          target = M_IDLE;
        end
      end
      default: begin
        // Error mode.
        hard_nxt   = 1'b1;
        enable_nxt = 1'b0;
        if (in_mode > {12'd0, cfg.error_hold_ms} &&
            item.event_code == rsm_pkg::EV_COMMAND) begin
          go     = 1'b1;
          target = M_IDLE;
        end
      end
    endcase

    // Leaving a driving mode ramps down; entering a mode sets the motor flags.
    if (go && target != mode_r) begin
      if (mode_r == M_MANUAL || mode_r == M_AUTO) begin
        ramp_nxt = rsm_pkg::RAMP_500;
      end
      mode_nxt  = target;
      entry_nxt = item.now_ms;
      if (target == M_IDLE || target == M_MANUAL) begin
        enable_nxt = 1'b1;
      end else if (target == M_ESTOP) begin
        hard_nxt   = 1'b1;
        enable_nxt = 1'b0;
      end
    end

    dir_nxt   = drive_nxt ? item.cmd_direction : 4'd0;
    speed_nxt = drive_nxt ? item.cmd_speed : 8'd0;
  end

  // Mode state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_INIT;
      entry_r     <= 32'd0;
      enable_r    <= 1'b0;
      estop_r     <= 1'b0;
      latched_r   <= 1'b0;
      rec_start_r <= 32'd0;
      rec_emerg_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= take || (out_valid_r && out_stall);
      if (take) begin
        mode_r      <= mode_nxt;
        entry_r     <= entry_nxt;
        enable_r    <= enable_nxt;
        estop_r     <= estop_nxt;
        latched_r   <= latched_nxt;
        rec_start_r <= rec_start_nxt;
        rec_emerg_r <= rec_emerg_nxt;
      end
    end
  end

  // Per-tick motor commands.
  always_ff @(posedge clk) begin
    if (take) begin
      drive_r     <= drive_nxt;
      dir_r       <= dir_nxt;
      speed_r     <= speed_nxt;
      ramp_r      <= ramp_nxt;
      hard_r      <= hard_nxt;
      start_rec_r <= start_rec_nxt;
    end
  end

  // The flags after the tick are the state itself.
  assign out_valid           = out_valid_r;
  assign out_mode            = mode_r;
  assign out_drive_valid     = drive_r;
  assign out_drive_direction = dir_r;
  assign out_drive_speed     = speed_r;
  assign out_soft_stop_ramp  = ramp_r;
  assign out_hard_stop       = hard_r;
  assign out_start_recovery  = start_rec_r;
  assign out_motors_allowed  = enable_r;
  assign out_estop_flag      = estop_r;

  // Emergency stop mode never leaves the motors enabled.
  a_estop_disables: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && mode_r == M_ESTOP) |-> !enable_r)
    else $error("motors enabled in emergency stop");

  // The e-stop flag is only ever set while in emergency stop mode.
  a_estop_flag_mode: assert property (@(posedge clk) disable iff (!rst_n)
    estop_r |-> (mode_r == M_ESTOP))
    else $error("estop flag outside emergency stop mode");

  // A recovery latch leaves the block in recovery or, on a button, in e-stop.
  a_latch_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && start_rec_r) |-> (mode_r == M_RECOVERY || mode_r == M_ESTOP))
    else $error("recovery started outside recovery");

  // Every taken word produces a result in the next cycle.
  a_take_result: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("taken word produced no result");

endmodule

### src/robot_supervisory_mode_fsm.sv
// ----------------------------------------------------------------------------
// Robot supervisory mode controller
// Path: a word accepted into the input register moves on to the result
// register when the core takes it. Throughput: one tick word per cycle
// while out_stall is low; the mode register update is the loop.
// Reset: rst_n low clears the mode to init, the mode flags and stamps to zero,
// and loads the configuration registers with their default limits.
// ----------------------------------------------------------------------------
module robot_supervisory_mode_fsm (
  input  logic                           clk,
  input  logic                           rst_n,
  // Tick channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    in_now_ms,
  input  logic [2:0]                     in_event_code,
  input  logic [3:0]                     in_cmd_direction,
  input  logic [7:0]                     in_cmd_speed,
  input  logic                           in_recovery_is_emergency,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_mode,
  output logic                           out_drive_valid,
  output logic [3:0]                     out_drive_direction,
  output logic [7:0]                     out_drive_speed,
  output logic [1:0]                     out_soft_stop_ramp,
  output logic                           out_hard_stop,
  output logic                           out_start_recovery,
  output logic                           out_motors_allowed,
  output logic                           out_estop_flag,
  // Configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rsm_pkg::item_t in_item;
  rsm_pkg::item_t item;
  rsm_pkg::cfg_t  cfg;
  logic           item_valid;
  logic           take;

  // Bundle the tick word.
  assign in_item.now_ms                = in_now_ms;
  assign in_item.event_code            = in_event_code;
  assign in_item.cmd_direction         = in_cmd_direction;
  assign in_item.cmd_speed             = in_cmd_speed;
  assign in_item.recovery_is_emergency = in_recovery_is_emergency;

  rsm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rsm_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  rsm_core u_core (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .item_valid          (item_valid),
    .item                (item),
    .take                (take),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_mode            (out_mode),
    .out_drive_valid     (out_drive_valid),
    .out_drive_direction (out_drive_direction),
    .out_drive_speed     (out_drive_speed),
    .out_soft_stop_ramp  (out_soft_stop_ramp),
    .out_hard_stop       (out_hard_stop),
    .out_start_recovery  (out_start_recovery),
    .out_motors_allowed  (out_motors_allowed),
    .out_estop_flag      (out_estop_flag)
  );

endmodule

### verif/tb_robot_supervisory_mode_fsm.sv
// ----------------------------------------------------------------------------
// Testbench for the robot supervisory mode controller
// Tick words go in on a valid/stall channel and results come back on another.
// Each accepted tick is run through a behavioral copy of the mode machine, and
// every result is checked field by field against the oldest prediction. The
// run walks through several limit settings, from all zero to all ones, with
// random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_robot_supervisory_mode_fsm;

  // Mode codes as the block encodes them.
  typedef enum logic [2:0] {
    M_INIT, M_IDLE, M_MANUAL, M_AUTO, M_RECOVERY, M_ESTOP, M_HOME, M_ERROR
  } mode_e;

  // Indexes past the last register; writes to them must be dropped.
  localparam logic [rsm_pkg::CFG_IDX_W-1:0] REG_SPARE_A = rsm_pkg::REG_STOP_DIR + 3'd1;
  localparam logic [rsm_pkg::CFG_IDX_W-1:0] REG_SPARE_B = '1;

  localparam int STALL_LIMIT = 2000;

  // One result word.
  typedef struct packed {
    logic [2:0] mode;
    logic       drive_valid;
    logic [3:0] drive_direction;
    logic [7:0] drive_speed;
    logic [1:0] soft_stop_ramp;
    logic       hard_stop;
    logic       start_recovery;
    logic       motors_allowed;
    logic       estop_flag;
  } tick_result_t;

  // Mode machine predictor and queue of expected result words.
  class mode_scoreboard;
    logic [15:0] entry_window;
    logic [19:0] rec_duration, estop_hold, home_return, error_hold;
    logic [3:0]  stop_dir;
    mode_e       mode;
    logic [31:0] entered_at, rec_stamp;
    bit          motors_on, estop_on, rec_latched, rec_emerg;
    logic [1:0]  ramp_now;
    bit          hard_now;
    tick_result_t expected_q[$];
    int failures, ticks, latches, estops, homings;

    function new();
      entry_window = rsm_pkg::RST_ENTRY_WINDOW;
      rec_duration = rsm_pkg::RST_REC_DURATION;
      estop_hold   = rsm_pkg::RST_ESTOP_HOLD;
      home_return  = rsm_pkg::RST_HOME_RETURN;
      error_hold   = rsm_pkg::RST_ERROR_HOLD;
      stop_dir     = rsm_pkg::RST_STOP_DIR;
      mode         = M_INIT;
      entered_at   = '0;
      rec_stamp    = '0;
      motors_on    = 0;
      estop_on     = 0;
      rec_latched  = 0;
      rec_emerg    = 0;
      failures     = 0;
      ticks        = 0;
      latches      = 0;
      estops       = 0;
      homings      = 0;
    endfunction

    // A register write; unknown indexes are ignored and values are masked.
    function void write_limit(logic [rsm_pkg::CFG_IDX_W-1:0] idx,
                              logic [rsm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        rsm_pkg::REG_ENTRY_WINDOW: entry_window = data[15:0];
        rsm_pkg::REG_REC_DURATION: rec_duration = data;
        rsm_pkg::REG_ESTOP_HOLD:   estop_hold   = data;
        rsm_pkg::REG_HOME_RETURN:  home_return  = data;
        rsm_pkg::REG_ERROR_HOLD:   error_hold   = data;
        rsm_pkg::REG_STOP_DIR:     stop_dir     = data[3:0];
        default: ;
      endcase
    endfunction

    // Mode change with its exit and entry actions; a change to the same mode is a no-op.
    function void enter(mode_e target, logic [31:0] now);
      if (target == mode) return;
      if (mode == M_MANUAL || mode == M_AUTO) ramp_now = rsm_pkg::RAMP_500;
      mode = target;
      entered_at = now;
      if (target == M_IDLE || target == M_MANUAL) begin
        motors_on = 1;
      end else if (target == M_ESTOP) begin
        hard_now = 1;
        motors_on = 0;
        estops++;
      end
      if (target == M_HOME) homings++;
    endfunction

    // Predicts the result word of one accepted tick.
    function void note_tick(rsm_pkg::item_t t);
      logic [31:0] in_mode, since_latch;
      tick_result_t r;
      in_mode  = t.now_ms - entered_at;
      r        = '0;
      ramp_now = rsm_pkg::RAMP_NONE;
      hard_now = 0;
      ticks++;
      case (mode)
        M_INIT: enter(M_IDLE, t.now_ms);
        M_IDLE: begin
          if (t.event_code == rsm_pkg::EV_COMMAND && t.cmd_direction != stop_dir)
            enter(M_MANUAL, t.now_ms);
          else if (t.event_code == rsm_pkg::EV_BUTTON || t.event_code == rsm_pkg::EV_SMOKE)
            enter(M_ESTOP, t.now_ms);
          else if (t.event_code == rsm_pkg::EV_TIME_LIMIT)
            enter(M_HOME, t.now_ms);
        end
        M_MANUAL, M_AUTO: begin
          if (motors_on && !estop_on) begin
            r.drive_valid     = 1'b1;
            r.drive_direction = t.cmd_direction;
            r.drive_speed     = t.cmd_speed;
          end
          if (t.event_code == rsm_pkg::EV_STUCK)
            enter(M_RECOVERY, t.now_ms);
          else if (t.event_code == rsm_pkg::EV_BUTTON || t.event_code == rsm_pkg::EV_SMOKE ||
                   t.event_code == rsm_pkg::EV_POWER_FAIL)
            enter(M_ESTOP, t.now_ms);
          else if (t.event_code == rsm_pkg::EV_COMMAND && t.cmd_direction == stop_dir)
            enter(M_IDLE, t.now_ms);
          else if (t.event_code == rsm_pkg::EV_TIME_LIMIT)
            enter(M_HOME, t.now_ms);
        end
        M_RECOVERY: begin
          // The action is latched once, early in the stay; later ticks reuse the stamp.
          if (in_mode < entry_window && !rec_latched) begin
            rec_emerg        = t.recovery_is_emergency;
            r.start_recovery = 1'b1;
            rec_stamp        = t.now_ms;
            rec_latched      = 1;
            latches++;
          end
          since_latch = t.now_ms - rec_stamp;
          if (since_latch > rec_duration) begin
            rec_latched = 0;
            enter(rec_emerg ? M_ESTOP : M_IDLE, t.now_ms);
          end
          if (t.event_code == rsm_pkg::EV_BUTTON) begin
            rec_latched = 0;
            enter(M_ESTOP, t.now_ms);
          end
        end
        M_ESTOP: begin
          hard_now  = 1;
          estop_on  = 1;
          motors_on = 0;
          if (in_mode > estop_hold) begin
            estop_on = 0;
            enter(M_IDLE, t.now_ms);
          end
        end
        M_HOME: begin
          ramp_now = rsm_pkg::RAMP_1000;
          if (in_mode > home_return) enter(M_IDLE, t.now_ms);
        end
        default: begin
          hard_now  = 1;
          motors_on = 0;
          if (in_mode > error_hold && t.event_code == rsm_pkg::EV_COMMAND)
            enter(M_IDLE, t.now_ms);
        end
      endcase
      r.mode           = mode;
      r.soft_stop_ramp = ramp_now;
      r.hard_stop      = hard_now;
      r.motors_allowed = motors_on;
      r.estop_flag     = estop_on;
      expected_q.push_back(r);
    endfunction

    function void same(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    // Checks one result word against the oldest prediction.
    function void check_result(tick_result_t got);
      tick_result_t want;
      if (expected_q.size() == 0) begin
        $error("result word with no prediction waiting");
        failures++;
        return;
      end
      want = expected_q.pop_front();
      same("mode", want.mode, got.mode);
      same("drive_valid", want.drive_valid, got.drive_valid);
      same("drive_direction", want.drive_direction, got.drive_direction);
      same("drive_speed", want.drive_speed, got.drive_speed);
      same("soft_stop_ramp", want.soft_stop_ramp, got.soft_stop_ramp);
      same("hard_stop", want.hard_stop, got.hard_stop);
      same("start_recovery", want.start_recovery, got.start_recovery);
      same("motors_allowed", want.motors_allowed, got.motors_allowed);
      same("estop_flag", want.estop_flag, got.estop_flag);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                           clk, rst_n;
  logic                           in_valid, in_stall;
  logic [31:0]                    in_now_ms;
  logic [2:0]                     in_event_code;
  logic [3:0]                     in_cmd_direction;
  logic [7:0]                     in_cmd_speed;
  logic                           in_recovery_is_emergency;
  logic                           out_valid, out_stall;
  logic [2:0]                     out_mode;
  logic                           out_drive_valid;
  logic [3:0]                     out_drive_direction;
  logic [7:0]                     out_drive_speed;
  logic [1:0]                     out_soft_stop_ramp;
  logic                           out_hard_stop, out_start_recovery;
  logic                           out_motors_allowed, out_estop_flag;
  logic                           cfg_valid, cfg_ready;
  logic [rsm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rsm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  mode_scoreboard sb;
  logic [31:0]    clock_ms;
  logic [3:0]     stop_code;
  bit             quiet, hold_off_req;
  int             settings, idle_cycles;
  tick_result_t   seen;

  robot_supervisory_mode_fsm u_top (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_now_ms                (in_now_ms),
    .in_event_code            (in_event_code),
    .in_cmd_direction         (in_cmd_direction),
    .in_cmd_speed             (in_cmd_speed),
    .in_recovery_is_emergency (in_recovery_is_emergency),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_mode                 (out_mode),
    .out_drive_valid          (out_drive_valid),
    .out_drive_direction      (out_drive_direction),
    .out_drive_speed          (out_drive_speed),
    .out_soft_stop_ramp       (out_soft_stop_ramp),
    .out_hard_stop            (out_hard_stop),
    .out_start_recovery       (out_start_recovery),
    .out_motors_allowed       (out_motors_allowed),
    .out_estop_flag           (out_estop_flag),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_index                (cfg_index),
    .cfg_wdata                (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Gap length shared by both sides: mostly none, some short, a few long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Next timestamp: small steps, steps around the limit scale, huge jumps and
  // an occasional arbitrary value that may land behind the current time.
  function automatic logic [31:0] next_stamp(logic [31:0] prev, int unsigned scale);
    int r;
    r = $urandom_range(0, 19);
    if (r < 6)  return prev + $urandom_range(0, 20);
    if (r < 12) return prev + $urandom_range(0, scale);
    if (r < 17) return prev + $urandom_range(scale / 2, scale * 2 + 2);
    if (r < 19) return prev + $urandom_range(0, 2000000);
    return $urandom();
  endfunction

  function automatic logic [2:0] pick_event();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return rsm_pkg::EV_NONE;
    if (r < 55) return rsm_pkg::EV_COMMAND;
    if (r < 61) return rsm_pkg::EV_BUTTON;
    if (r < 66) return rsm_pkg::EV_SMOKE;
    if (r < 74) return rsm_pkg::EV_TIME_LIMIT;
    if (r < 88) return rsm_pkg::EV_STUCK;
    if (r < 94) return rsm_pkg::EV_POWER_FAIL;
    if (r < 97) return rsm_pkg::EV_SPARE;
    return rsm_pkg::EV_NONE;
  endfunction

  // Offers one tick word after a random gap and returns once it is taken.
  task automatic drive_tick(rsm_pkg::item_t t);
    int gap;
    gap = quiet ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid                 <= 1'b1;
    in_now_ms                <= t.now_ms;
    in_event_code            <= t.event_code;
    in_cmd_direction         <= t.cmd_direction;
    in_cmd_speed             <= t.cmd_speed;
    in_recovery_is_emergency <= t.recovery_is_emergency;
    do @(posedge clk); while (in_stall);
    sb.note_tick(t);
  endtask

  task automatic advance_tick(int unsigned step, logic [2:0] ev, logic [3:0] dir,
                              logic [7:0] spd, bit rie);
    rsm_pkg::item_t t;
    clock_ms = clock_ms + step;
    t.now_ms = clock_ms;
    t.event_code = ev;
    t.cmd_direction = dir;
    t.cmd_speed = spd;
    t.recovery_is_emergency = rie;
    drive_tick(t);
  endtask

  task automatic write_reg(logic [rsm_pkg::CFG_IDX_W-1:0] idx,
                           logic [rsm_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_limit(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Withdraws the last offered word, waits until every predicted word has
  // come back, then lets the pipe drain.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_limits(logic [15:0] win, logic [19:0] dur, logic [19:0] est,
                             logic [19:0] home, logic [19:0] err, logic [3:0] stop);
    settle();
    write_reg(rsm_pkg::REG_ENTRY_WINDOW, {4'd0, win});
    write_reg(rsm_pkg::REG_REC_DURATION, dur);
    write_reg(rsm_pkg::REG_ESTOP_HOLD, est);
    write_reg(rsm_pkg::REG_HOME_RETURN, home);
    write_reg(rsm_pkg::REG_ERROR_HOLD, err);
    write_reg(rsm_pkg::REG_STOP_DIR, {16'd0, stop});
    stop_code = stop;
    settings++;
  endtask

  // Random ticks; a steady run keeps the sender from idling.
  task automatic run_random(int count, int unsigned scale, bit steady);
    rsm_pkg::item_t t;
    for (int i = 0; i < count; i++) begin
      if (steady) quiet = 1'b1;
      else if (i % 64 == 0) quiet = ($urandom_range(0, 4) == 0);
      clock_ms = next_stamp(clock_ms, scale);
      t.now_ms = clock_ms;
      t.event_code = pick_event();
      if ($urandom_range(0, 3) == 0) t.cmd_direction = stop_code;
      else t.cmd_direction = $urandom_range(0, 15);
      t.cmd_speed = $urandom_range(0, 255);
      t.recovery_is_emergency = $urandom_range(0, 1);
      drive_tick(t);
    end
    quiet = 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int run;
    out_stall = 1'b0;
    run = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        run = 80;
      end else if (run == 0 && !quiet) begin
        run = idle_len();
      end
      if (run > 0) begin
        out_stall <= 1'b1;
        run--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every accepted result word goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.mode            = out_mode;
      seen.drive_valid     = out_drive_valid;
      seen.drive_direction = out_drive_direction;
      seen.drive_speed     = out_drive_speed;
      seen.soft_stop_ramp  = out_soft_stop_ramp;
      seen.hard_stop       = out_hard_stop;
      seen.start_recovery  = out_start_recovery;
      seen.motors_allowed  = out_motors_allowed;
      seen.estop_flag      = out_estop_flag;
      sb.check_result(seen);
    end
  end

  // Watchdog on cycles in which no channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without progress", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    sb                       = new();
    rst_n                    = 1'b0;
    in_valid                 = 1'b0;
    in_now_ms                = '0;
    in_event_code            = '0;
    in_cmd_direction         = '0;
    in_cmd_speed             = '0;
    in_recovery_is_emergency = 1'b0;
    cfg_valid                = 1'b0;
    cfg_index                = '0;
    cfg_wdata                = '0;
    clock_ms                 = '0;
    stop_code                = rsm_pkg::RST_STOP_DIR;
    quiet                    = 1'b0;
    hold_off_req             = 1'b0;
    settings                 = 1;
    idle_cycles              = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk through the reachable mode paths with the default limits.
    advance_tick(0, rsm_pkg::EV_NONE, 4'd0, 8'd0, 1'b0);          // init moves to idle
    advance_tick(5, rsm_pkg::EV_COMMAND, 4'd0, 8'd10, 1'b0);      // stop command stays idle
    advance_tick(5, rsm_pkg::EV_SPARE, 4'd15, 8'd255, 1'b1);      // unused code acts as none
    advance_tick(5, rsm_pkg::EV_COMMAND, 4'd15, 8'd255, 1'b0);    // to manual
    advance_tick(5, rsm_pkg::EV_NONE, 4'd15, 8'd255, 1'b0);       // drive at full speed
    advance_tick(5, rsm_pkg::EV_SPARE, 4'd1, 8'd0, 1'b0);
    advance_tick(5, rsm_pkg::EV_COMMAND, 4'd0, 8'd0, 1'b0);       // stop command, soft stop
    advance_tick(5, rsm_pkg::EV_COMMAND, 4'd9, 8'd128, 1'b0);
    advance_tick(5, rsm_pkg::EV_STUCK, 4'd9, 8'd128, 1'b0);       // to recovery
    advance_tick(10, rsm_pkg::EV_NONE, 4'd0, 8'd0, 1'b1);         // latch emergency action
    advance_tick(1000, rsm_pkg::EV_NONE, 4'd0, 8'd0, 1'b0);
    advance_tick(2001, rsm_pkg::EV_NONE, 4'd0, 8'd0, 1'b0);       // completes into e-stop
    advance_tick(5000, rsm_pkg::EV_NONE, 4'd0, 8'd0, 1'b0);       // exactly at the hold limit
    advance_tick(1, rsm_pkg::EV_NONE, 4'd0, 8'd0, 1'b0);          // released to idle
    advance_tick(5, rsm_pkg::EV_TIME_LIMIT, 4'd0, 8'd0, 1'b0);    // return home
    advance_tick(10001, rsm_pkg::EV_NONE, 4'd0, 8'd0, 1'b0);
    advance_tick(5, rsm_pkg::EV_SMOKE, 4'd0, 8'd0, 1'b0);
    advance_tick(5001, rsm_pkg::EV_NONE, 4'd0, 8'd0, 1'b0);
    advance_tick(5, rsm_pkg::EV_COMMAND, 4'd3, 8'd77, 1'b0);
    advance_tick(5, rsm_pkg::EV_POWER_FAIL, 4'd3, 8'd77, 1'b0);   // power fail from manual
    advance_tick(6000, rsm_pkg::EV_NONE, 4'd0, 8'd0, 1'b0);
    advance_tick(5, rsm_pkg::EV_COMMAND, 4'd2, 8'd200, 1'b0);
    advance_tick(5, rsm_pkg::EV_STUCK, 4'd2, 8'd200, 1'b0);
    // Window missed: the stale latch stamp decides, then the button wins.
    advance_tick(200, rsm_pkg::EV_BUTTON, 4'd0, 8'd0, 1'b0);
    clock_ms = 32'hFFFF_FFF0;
    advance_tick(15, rsm_pkg::EV_NONE, 4'd0, 8'd0, 1'b1);         // all-ones timestamp
    advance_tick(32, rsm_pkg::EV_BUTTON, 4'd0, 8'd0, 1'b0);       // timestamp wraps past zero

    // Default limits, with a long receiver hold-off while ticks keep coming.
    run_random(160, 3000, 1'b0);
    hold_off_req = 1'b1;
    run_random(30, 3000, 1'b1);
    settle();
    run_random(150, 3000, 1'b0);

    // Short limits and a nonzero stop code.
    load_limits(16'd40, 20'd150, 20'd200, 20'd300, 20'd50, 4'd7);
    run_random(320, 200, 1'b0);

    // Every limit at zero.
    load_limits(16'd0, 20'd0, 20'd0, 20'd0, 20'd0, 4'd15);
    run_random(300, 3, 1'b0);

    // Every limit at its maximum, an oversized window value, spare indexes.
    load_limits(16'hFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 4'd0);
    write_reg(rsm_pkg::REG_ENTRY_WINDOW, 20'hFFFFF);
    write_reg(REG_SPARE_A, 20'h00001);
    write_reg(REG_SPARE_B, 20'hABCDE);
    run_random(320, 600000, 1'b0);
    hold_off_req = 1'b1;
    run_random(30, 600000, 1'b1);

    // Random limits.
    load_limits($urandom_range(0, 300), $urandom_range(0, 5000), $urandom_range(0, 5000),
                $urandom_range(0, 5000), $urandom_range(0, 5000), $urandom_range(0, 15));
    run_random(320, 3000, 1'b0);

    // Back to the reset defaults.
    load_limits(rsm_pkg::RST_ENTRY_WINDOW, rsm_pkg::RST_REC_DURATION,
                rsm_pkg::RST_ESTOP_HOLD, rsm_pkg::RST_HOME_RETURN,
                rsm_pkg::RST_ERROR_HOLD, rsm_pkg::RST_STOP_DIR);
    run_random(300, 3000, 1'b0);

    settle();

    if (sb.pending() != 0) begin
      $error("%0d predicted result words never arrived", sb.pending());
      sb.failures++;
    end
    $display("covered %0d ticks under %0d limit settings: %0d recovery latches,",
             sb.ticks, settings, sb.latches);
    $display("  %0d emergency stop entries and %0d return-home runs", sb.estops, sb.homings);
    if (sb.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
